FILE: sv/decimal_accumulator_cpu_step_macros.svh
`ifndef DECIMAL_ACCUMULATOR_CPU_STEP_MACROS_SVH
`define DECIMAL_ACCUMULATOR_CPU_STEP_MACROS_SVH

// property that must hold at every edge outside reset
`define DACS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DACS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dacs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dacs_pkg;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [6:0]         addr;
        logic signed [31:0] value;
    } dacs_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [6:0]         pc_now;
        logic signed [31:0] acc_now;
        logic               out_valid;
        logic [6:0]         out_addr;
        logic signed [31:0] out_value;
        logic               overflow_warn;
        logic               neg_flag;
        logic               zero_flag;
        logic               ovf_flag;
    } dacs_rsp_t;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_HALT  = 3'd1;
    localparam logic [2:0] ST_BADOP = 3'd2;
    localparam logic [2:0] ST_UNDER = 3'd3;
    localparam logic [2:0] ST_DIVZ  = 3'd4;
    localparam logic [2:0] ST_END   = 3'd5;

    localparam logic [5:0] OP_NONE   = 6'd0;
    localparam logic [5:0] OP_READ   = 6'd10;
    localparam logic [5:0] OP_WRITE  = 6'd11;
    localparam logic [5:0] OP_LOAD   = 6'd20;
    localparam logic [5:0] OP_STORE  = 6'd21;
    localparam logic [5:0] OP_ADD    = 6'd30;
    localparam logic [5:0] OP_SUB    = 6'd31;
    localparam logic [5:0] OP_DIV    = 6'd32;
    localparam logic [5:0] OP_MUL    = 6'd33;
    localparam logic [5:0] OP_BR     = 6'd40;
    localparam logic [5:0] OP_BRNEG  = 6'd41;
    localparam logic [5:0] OP_BRZERO = 6'd42;
    localparam logic [5:0] OP_BRCARR = 6'd43;
    localparam logic [5:0] OP_BROVF  = 6'd44;
    localparam logic [5:0] OP_HALT   = 6'd45;

    localparam logic signed [31:0] LIM_HI = 32'sd9999;
    localparam logic signed [31:0] LIM_LO = -32'sd9999;

    // reciprocal of 100 for 32-bit unsigned words, product shifted right by 37
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
    localparam int          DIV100_SHIFT = 37;
    localparam logic [6:0]  WORD_BASE    = 7'd100;

endpackage
`default_nettype wire

FILE: sv/dacs_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module dacs_mem #(
    parameter int MEM_WORDS = 100
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [6:0]  wr_addr,
    input  wire logic [31:0] wr_data,
    input  wire logic        rd_en,
    input  wire logic [6:0]  rd_addr,
    output logic [31:0]      rd_data
);
    localparam int AW = $clog2(MEM_WORDS);

    logic [31:0]          mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] vld_reg;
    logic [31:0]          data_reg;
    logic                 hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    // words never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr[AW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= vld_reg[rd_addr[AW-1:0]];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;
endmodule
`default_nettype wire

FILE: sv/dacs_div.sv
`timescale 1ns / 1ps
`default_nettype none
module dacs_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dsr_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[31]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!rem_sub[32])
            begin
                rem_reg <= rem_sub[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

FILE: sv/decimal_accumulator_cpu_step.sv
`timescale 1ns / 1ps
`default_nettype none
// One request at a time: load and start commands, and steps that find the machine stopped or
// the counter past the end, go from acceptance straight to the response state; a step that runs
// an instruction reads the instruction word and then its operand from the word memory, which has
// one read port and one write port, and a divide waits for the bit-serial divider. The memory
// reads as zero after reset with no clearing pass. A response waits in an output register, and
// the next request is taken while it waits.
module decimal_accumulator_cpu_step #(
    parameter int MEM_WORDS = 100
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire dacs_pkg::dacs_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output dacs_pkg::dacs_rsp_t    rsp
);
    import dacs_pkg::*;

    `include "decimal_accumulator_cpu_step_macros.svh"

    localparam logic [6:0] WORDS = 7'(MEM_WORDS);

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_DEC1, S_DEC2, S_OPND, S_EXEC, S_DIVW, S_ARITH, S_DONE
    } state_t;

    state_t             state_reg;
    logic [6:0]         pc_reg;
    logic signed [31:0] acc_reg;
    logic               neg_reg, zero_reg, ovf_reg;
    logic [2:0]         status_reg;
    logic [31:0]        w_reg;
    logic [24:0]        q_reg;
    logic [5:0]         opc_reg;
    logic [6:0]         op_reg;
    logic signed [31:0] m_reg;
    logic signed [31:0] val_reg;
    logic signed [63:0] res_reg;
    logic               ov_reg;
    logic [6:0]         oaddr_reg;
    logic signed [31:0] ovalue_reg;
    logic               warn_reg;
    dacs_rsp_t          rsp_reg;
    logic               rsp_vld_reg;

    logic               acc_ok;
    logic               wr_en, rd_en;
    logic [6:0]         wr_addr, rd_addr;
    logic [31:0]        wr_data, rd_data;
    logic [63:0]        recip;
    logic [31:0]        hundreds;
    logic [6:0]         rem100;
    logic               div_start, div_done;
    logic [31:0]        div_q, a_mag, m_mag;
    logic signed [63:0] sat_in;
    logic signed [31:0] sat_out;
    logic [6:0]         pc_inc;

    assign acc_ok    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign pc_inc    = pc_reg + 7'd1;

    // divide by 100 through the reciprocal, then the remainder
    assign recip    = {32'b0, w_reg} * {32'b0, DIV100_MAGIC};
    assign hundreds = {7'b0, q_reg} * 32'(WORD_BASE);
    assign rem100   = w_reg[6:0] - hundreds[6:0];

    assign a_mag = acc_reg[31] ? 32'(-acc_reg) : acc_reg;
    assign m_mag = m_reg[31] ? 32'(-m_reg) : m_reg;
    assign div_start = (state_reg == S_EXEC) && (opc_reg == OP_DIV) && (m_reg != 32'sd0);

    assign sat_in  = res_reg;
    assign sat_out = (sat_in > 64'sd2147483647) ? 32'sh7FFFFFFF :
                     (sat_in < -64'sd2147483648) ? 32'sh80000000 : sat_in[31:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = req.addr;
        wr_data = req.value;
        rd_en   = 1'b0;
        rd_addr = pc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc_ok && req.cmd == CMD_LOAD && req.addr < WORDS)
                begin
                    wr_en = 1'b1;
                end
                rd_en = acc_ok && req.cmd == CMD_STEP && status_reg == ST_RUN
                        && pc_reg < WORDS;
            end
            S_DEC2:
            begin
                rd_en   = !w_reg[31];
                rd_addr = rem100;
            end
            S_EXEC:
            begin
                wr_addr = op_reg;
                if (opc_reg == OP_READ)
                begin
                    wr_en   = 1'b1;
                    wr_data = val_reg;
                end
                else if (opc_reg == OP_STORE)
                begin
                    wr_en   = 1'b1;
                    wr_data = acc_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    dacs_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dacs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_mag),
        .divisor  (m_mag),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            zero_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            status_reg  <= ST_RUN;
            rsp_vld_reg <= 1'b0;
            ov_reg      <= 1'b0;
            warn_reg    <= 1'b0;
        end
        else
        begin
            if (rsp_vld_reg && rsp_ready && state_reg != S_DONE)
            begin
                rsp_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc_ok)
                    begin
                        ov_reg     <= 1'b0;
                        warn_reg   <= 1'b0;
                        oaddr_reg  <= '0;
                        ovalue_reg <= '0;
                        val_reg    <= req.value;
                        state_reg  <= S_DONE;
                        if (req.cmd == CMD_START)
                        begin
                            pc_reg     <= (req.addr < WORDS) ? req.addr : WORDS;
                            acc_reg    <= req.value;
                            status_reg <= ST_RUN;
                        end
                        else if (req.cmd == CMD_STEP && status_reg == ST_RUN)
                        begin
                            if (pc_reg >= WORDS)
                            begin
                                status_reg <= ST_END;
                            end
                            else
                            begin
                                state_reg <= S_FETCH;
                            end
                        end
                    end
                end
                S_FETCH:
                begin
                    w_reg     <= rd_data;
                    state_reg <= S_DEC1;
                end
                S_DEC1:
                begin
                    q_reg     <= recip[DIV100_SHIFT+24:DIV100_SHIFT];
                    state_reg <= S_DEC2;
                end
                S_DEC2:
                begin
                    // a negative word never decodes to a valid opcode
                    opc_reg   <= (!w_reg[31] && q_reg < 25'd64) ? q_reg[5:0] : OP_NONE;
                    op_reg    <= rem100;
                    state_reg <= S_OPND;
                end
                S_OPND:
                begin
                    m_reg     <= rd_data;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                    case (opc_reg)
                        OP_READ:
                        begin
                            if (val_reg < LIM_LO)
                            begin
                                status_reg <= ST_UNDER;
                            end
                            else
                            begin
                                if (val_reg > LIM_HI)
                                begin
                                    warn_reg <= 1'b1;
                                    neg_reg  <= acc_reg < 32'sd0;
                                    zero_reg <= acc_reg == 32'sd0;
                                    ovf_reg  <= acc_reg > LIM_HI;
                                end
                                pc_reg <= pc_inc;
                            end
                        end
                        OP_WRITE:
                        begin
                            ov_reg     <= 1'b1;
                            oaddr_reg  <= op_reg;
                            ovalue_reg <= m_reg;
                            pc_reg     <= pc_inc;
                        end
                        OP_LOAD:
                        begin
                            acc_reg <= m_reg;
                            pc_reg  <= pc_inc;
                        end
                        OP_STORE:
                        begin
                            pc_reg <= pc_inc;
                        end
                        OP_ADD:
                        begin
                            res_reg   <= 64'(acc_reg) + 64'(m_reg);
                            state_reg <= S_ARITH;
                        end
                        OP_SUB:
                        begin
                            res_reg   <= 64'(acc_reg) - 64'(m_reg);
                            state_reg <= S_ARITH;
                        end
                        OP_DIV:
                        begin
                            if (m_reg == 32'sd0)
                            begin
                                pc_reg     <= pc_inc;
                                status_reg <= ST_DIVZ;
                            end
                            else
                            begin
                                state_reg <= S_DIVW;
                            end
                        end
                        OP_MUL:
                        begin
                            res_reg   <= 64'(acc_reg) * 64'(m_reg);
                            state_reg <= S_ARITH;
                        end
                        OP_BR:
                        begin
                            pc_reg <= op_reg;
                        end
                        OP_BRNEG:
                        begin
                            pc_reg <= neg_reg ? op_reg : pc_inc;
                        end
                        OP_BRZERO:
                        begin
                            pc_reg <= zero_reg ? op_reg : pc_inc;
                        end
                        OP_BRCARR:
                        begin
                            pc_reg <= pc_inc;
                        end
                        OP_BROVF:
                        begin
                            pc_reg <= ovf_reg ? op_reg : pc_inc;
                        end
                        OP_HALT:
                        begin
                            status_reg <= ST_HALT;
                        end
                        default:
                        begin
                            status_reg <= ST_BADOP;
                        end
                    endcase
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        res_reg   <= (acc_reg[31] ^ m_reg[31]) ? -$signed({32'b0, div_q})
                                                             : $signed({32'b0, div_q});
                        state_reg <= S_ARITH;
                    end
                end
                S_ARITH:
                begin
                    acc_reg  <= sat_out;
                    pc_reg   <= pc_inc;
                    neg_reg  <= sat_out < 32'sd0;
                    zero_reg <= sat_out == 32'sd0;
                    ovf_reg  <= sat_out > LIM_HI;
                    if (sat_out < LIM_LO)
                    begin
                        status_reg <= ST_UNDER;
                    end
                    else if (sat_out > LIM_HI)
                    begin
                        warn_reg <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!rsp_vld_reg || rsp_ready)
                    begin
                        rsp_vld_reg           <= 1'b1;
                        rsp_reg.status        <= status_reg;
                        rsp_reg.pc_now        <= pc_reg;
                        rsp_reg.acc_now       <= acc_reg;
                        rsp_reg.out_valid     <= ov_reg;
                        rsp_reg.out_addr      <= oaddr_reg;
                        rsp_reg.out_value     <= ovalue_reg;
                        rsp_reg.overflow_warn <= warn_reg;
                        rsp_reg.neg_flag      <= neg_reg;
                        rsp_reg.zero_flag     <= zero_reg;
                        rsp_reg.ovf_flag      <= ovf_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    `DACS_ASSERT_ALWAYS(a_pc_range, pc_reg <= WORDS, "program counter past end of memory")
    `DACS_ASSERT_ALWAYS(a_rd_range, !rd_en || rd_addr < WORDS, "memory read out of range")
    `DACS_ASSERT_NEXT(a_stop_holds, status_reg != ST_RUN && !(acc_ok && req.cmd == CMD_START),
        status_reg == $past(status_reg), "stopped machine changed status")
    `DACS_ASSERT_ALWAYS(a_write_running, !(rsp_valid && rsp.out_valid) || rsp.status == ST_RUN,
        "write output on a stopped machine")
endmodule
`default_nettype wire
